// ===== src/cmp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the cursor mask packer.
package cmp_pkg;

	// Register indexes on the configuration port (byte address is 4 times the index).
	localparam logic [1:0] REG_BLACK_CODE  = 2'd0;
	localparam logic [1:0] REG_WHITE_CODE  = 2'd1;
	localparam logic [1:0] REG_INVERT_CODE = 2'd2;
	localparam logic [1:0] REG_SIDE_BYTES  = 2'd3;

	// Pad pair written for row and end padding.
	localparam logic [7:0] PAD_AND = 8'd255;
	localparam logic [7:0] PAD_XOR = 8'd0;

	// Reset values of the configuration registers.
	localparam logic [7:0] BLACK_RESET  = 8'd88;
	localparam logic [7:0] WHITE_RESET  = 8'd46;
	localparam logic [7:0] INVERT_RESET = 8'd111;
	localparam logic [4:0] SIDE_RESET   = 5'd4;

	// Saturation limit of the character counter.
	localparam logic [14:0] TOTAL_MAX = 15'h7fff;

	// One output word.
	typedef struct packed {
		logic [7:0] and_byte;
		logic [7:0] xor_byte;
		logic [7:0] copies;
		logic       is_padding;
		logic       end_of_mask;
		logic       length_error;
	} res_t;

endpackage

// ===== src/cursor_mask_packer_top.sv =====
`timescale 1ns / 1ps
// Top level of the cursor mask packer: classification, packing and output queue.

// The cursor mask packer takes a square cursor picture one character per input
// word and turns it into AND/XOR mask byte pairs, eight pixels per pair, most
// significant bit first. Each character is compared with the black, white and
// invert codes held in the configuration registers. When the side in bytes is
// odd, every row is followed by one pad pair (255, 0), and the final character
// of the picture adds one end pad result that carries a copies count of
// (side + 1) * 8. The last result of a picture has end_of_mask set, and
// length_error tells whether the number of characters differed from 64 times
// the side squared. When an input word is taken, its state update and all of
// its results (up to three) are computed in a single pass and written into a
// four-entry output queue, which hands out one result per cycle unless the
// output is stalled. Input stalls only while the queue holds more than one
// result, so a character can be accepted in every cycle as long as the output
// side keeps up; a word that completes a byte, a row and the picture yields
// three results. Configuration registers sit on an APB-style port at byte
// addresses 0, 4, 8 and 12 and should only be written while the block is idle.
module cursor_mask_packer_top #(
	parameter int MAX_SIDE_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  pixel_char,
	input  logic        final_char,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  and_byte,
	output logic [7:0]  xor_byte,
	output logic [7:0]  copies,
	output logic        is_padding,
	output logic        end_of_mask,
	output logic        length_error
);
	import cmp_pkg::*;

	localparam int QDEPTH = 4;

	// Configuration registers.
	logic [7:0] black_q, white_q, invert_q;
	logic [4:0] side_q;

	// Packing state.
	logic [7:0]  and_shift_q, xor_shift_q;
	logic [2:0]  bit_index_q;
	logic [4:0]  row_idx_q;
	logic [14:0] total_q;

	// Output queue; entry 0 is the head.
	res_t       queue_q [QDEPTH];
	logic [2:0] cnt_q;

	// Per-word computation.
	logic        abit, xbit, byte_done, odd, row_end, push, pop, cfg_wr;
	logic [4:0]  side, row_inc;
	logic [7:0]  and_next, xor_next;
	logic [2:0]  bit_next;
	logic [14:0] total_next;
	logic [15:0] expect_cnt;
	logic        err;
	res_t        res [3];
	logic [1:0]  nres;
	logic [2:0]  base, cnt_next;

	// Configuration port. Writes complete in the access cycle; reads are direct.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_q  <= BLACK_RESET;
			white_q  <= WHITE_RESET;
			invert_q <= INVERT_RESET;
			side_q   <= SIDE_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BLACK_CODE:  black_q  <= pwdata[7:0];
				REG_WHITE_CODE:  white_q  <= pwdata[7:0];
				REG_INVERT_CODE: invert_q <= pwdata[7:0];
				REG_SIDE_BYTES:  side_q   <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_BLACK_CODE:  prdata = {24'd0, black_q};
			REG_WHITE_CODE:  prdata = {24'd0, white_q};
			REG_INVERT_CODE: prdata = {24'd0, invert_q};
			REG_SIDE_BYTES:  prdata = {27'd0, side_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Classification and packing of the incoming character.
	assign side = (side_q > 5'(MAX_SIDE_BYTES)) ? 5'(MAX_SIDE_BYTES) : side_q;
	assign odd  = side[0];

	assign abit = (pixel_char != black_q) && (pixel_char != white_q);
	assign xbit = (pixel_char == white_q) || (pixel_char == invert_q);

	assign and_next   = {and_shift_q[6:0], abit};
	assign xor_next   = {xor_shift_q[6:0], xbit};
	assign bit_next   = bit_index_q + 3'd1;
	assign byte_done  = (bit_next == 3'd0);
	assign total_next = (total_q < TOTAL_MAX) ? total_q + 15'd1 : total_q;

	// For an odd side, a row ends when the byte counter reaches or passes the side.
	assign row_inc = row_idx_q + 5'd1;
	assign row_end = byte_done && odd && (row_inc >= side);

	// Expected character count is 64 * side * side.
	assign expect_cnt = ({11'd0, side} * {11'd0, side}) << 6;
	assign err        = ({1'b0, total_next} != expect_cnt);

	// Results of this word, in order: data pair, row pad, end pad or marker.
	always_comb begin
		res_t data_r, pad_r, fin_r;
		logic [1:0] k;
		data_r = '{and_byte: and_next, xor_byte: xor_next, copies: 8'd1,
			is_padding: 1'b0, end_of_mask: 1'b0, length_error: 1'b0};
		pad_r  = '{and_byte: PAD_AND, xor_byte: PAD_XOR, copies: 8'd1,
			is_padding: 1'b1, end_of_mask: 1'b0, length_error: 1'b0};
		fin_r  = pad_r;
		fin_r.copies = odd ? (({3'd0, side} + 8'd1) << 3) : 8'd0;
		k = 2'd0;
		for (int i = 0; i < 3; i++) begin
			res[i] = pad_r;
		end
		if (byte_done) begin
			res[k] = data_r;
			k = k + 2'd1;
		end
		if (row_end) begin
			res[k] = pad_r;
			k = k + 2'd1;
		end
		if (final_char && (odd || (k == 2'd0))) begin
			res[k] = fin_r;
			k = k + 2'd1;
		end
		// The last result of the picture carries the end flag and length check.
		if (final_char) begin
			res[k - 2'd1].end_of_mask  = 1'b1;
			res[k - 2'd1].length_error = err;
		end
		nres = k;
	end

	// Handshakes. The queue must have room for three results before a word is taken.
	assign in_stall  = (cnt_q > 3'd1);
	assign push      = in_valid & ~in_stall;
	assign out_valid = (cnt_q != 3'd0);
	assign pop       = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			and_shift_q <= '0;
			xor_shift_q <= '0;
			bit_index_q <= '0;
			row_idx_q   <= '0;
			total_q     <= '0;
		end else if (push) begin
			if (final_char) begin
				and_shift_q <= '0;
				xor_shift_q <= '0;
				bit_index_q <= '0;
				row_idx_q   <= '0;
				total_q     <= '0;
			end else begin
				and_shift_q <= byte_done ? 8'd0 : and_next;
				xor_shift_q <= byte_done ? 8'd0 : xor_next;
				bit_index_q <= bit_next;
				total_q     <= total_next;
				if (byte_done && odd) begin
					row_idx_q <= row_end ? 5'd0 : row_inc;
				end
			end
		end
	end

	// Output queue: shift toward the head on a pop, append new results behind.
	assign base     = cnt_q - {2'd0, pop};
	assign cnt_next = base + (push ? {1'b0, nres} : 3'd0);

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			if (push && (3'(i) >= base) && (3'(i) < base + {1'b0, nres})) begin
				queue_q[i] <= res[2'(3'(i) - base)];
			end else if (pop && (i < QDEPTH - 1)) begin
				queue_q[i] <= queue_q[(i + 1) % QDEPTH];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_next;
		end
	end

	assign and_byte     = queue_q[0].and_byte;
	assign xor_byte     = queue_q[0].xor_byte;
	assign copies       = queue_q[0].copies;
	assign is_padding   = queue_q[0].is_padding;
	assign end_of_mask  = queue_q[0].end_of_mask;
	assign length_error = queue_q[0].length_error;

endmodule

// ===== src/cmp_checker.sv =====
`timescale 1ns / 1ps
// Port checker for the cursor mask packer and its bind to the top level.
module cmp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] and_byte,
	input logic [7:0] xor_byte,
	input logic [7:0] copies,
	input logic       is_padding,
	input logic       end_of_mask,
	input logic       length_error
);
	import cmp_pkg::*;

	// A stalled output word keeps its mask pair, copies, end flag and length flag until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(and_byte) && $stable(xor_byte)
			&& $stable(copies) && $stable(end_of_mask) && $stable(length_error))
		else $error("stalled output word changed");

	// The length flag only appears on the last word of a picture.
	a_err_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_mask |-> !length_error)
		else $error("length_error outside end of picture");

	// A data pair is always appended once.
	a_data_copies: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_padding |-> copies == 8'd1)
		else $error("data pair with copies other than one");

	// Padding words always carry the pad pair.
	a_pad_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_padding |-> and_byte == PAD_AND && xor_byte == PAD_XOR)
		else $error("padding word without pad pair");

endmodule

bind cursor_mask_packer_top cmp_checker u_cmp_checker (.*);

// ===== verif/cursor_mask_packer_checker.sv =====
`timescale 1ns / 1ps
// Checker for the cursor mask packer: mirrors the registers, predicts each mask word, compares.
module cursor_mask_packer_checker
	import cmp_pkg::*;
#(
	parameter int MAX_SIDE_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  pixel_char,
	input  logic        final_char,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  and_byte,
	input  logic [7:0]  xor_byte,
	input  logic [7:0]  copies,
	input  logic        is_padding,
	input  logic        end_of_mask,
	input  logic        length_error,
	output int          mismatches,
	output int          words_pending
);

	logic [7:0]  black_q, white_q, invert_q;
	logic [4:0]  side_q;
	logic [7:0]  and_acc, xor_acc;
	logic [2:0]  bit_pos;
	logic [4:0]  row_bytes;
	logic [14:0] char_count;
	res_t        mask_words_due[$];
	int          word_count = 0;

	initial mismatches = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mask word mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %0d %s is %0h, expected %0h", word_count, name, got,
				want));
	endtask

	// Shifts one character into the mask bytes and queues every word it causes.
	task automatic pack_char(input logic [7:0] ch, input logic last);
		logic [4:0]  side;
		logic        odd;
		logic [14:0] full_count;
		res_t        words [3];
		res_t        pad;
		int          n;
		side = (side_q > 5'(MAX_SIDE_BYTES)) ? 5'(MAX_SIDE_BYTES) : side_q;
		odd = side[0];
		n = 0;
		pad = '{and_byte: PAD_AND, xor_byte: PAD_XOR, copies: 8'd1, is_padding: 1'b1,
			end_of_mask: 1'b0, length_error: 1'b0};
		and_acc = {and_acc[6:0], (ch != black_q) && (ch != white_q)};
		xor_acc = {xor_acc[6:0], (ch == white_q) || (ch == invert_q)};
		bit_pos = bit_pos + 3'd1;
		if (char_count != TOTAL_MAX)
			char_count = char_count + 15'd1;
		if (bit_pos == 3'd0) begin
			words[n] = '{and_byte: and_acc, xor_byte: xor_acc, copies: 8'd1, is_padding: 1'b0,
				end_of_mask: 1'b0, length_error: 1'b0};
			n++;
			and_acc = '0;
			xor_acc = '0;
			if (odd) begin
				row_bytes = row_bytes + 5'd1;
				if (row_bytes >= side) begin
					row_bytes = '0;
					words[n] = pad;
					n++;
				end
			end
		end
		if (last) begin
			full_count = 15'(64 * side * side);
			if (odd) begin
				words[n] = pad;
				words[n].copies = 8'((side + 1) * 8);
				n++;
			end else if (n == 0) begin
				// Even side and no byte completed: a lone marker word closes the mask.
				words[n] = pad;
				words[n].copies = 8'd0;
				n++;
			end
			words[n - 1].end_of_mask = 1'b1;
			words[n - 1].length_error = (char_count != full_count);
			and_acc = '0;
			xor_acc = '0;
			bit_pos = '0;
			row_bytes = '0;
			char_count = '0;
		end
		for (int i = 0; i < n; i++)
			mask_words_due.insert(mask_words_due.size(), words[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got, want;
		if (!arst_n) begin
			black_q = BLACK_RESET;
			white_q = WHITE_RESET;
			invert_q = INVERT_RESET;
			side_q = SIDE_RESET;
			and_acc = '0;
			xor_acc = '0;
			bit_pos = '0;
			row_bytes = '0;
			char_count = '0;
			mask_words_due.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_BLACK_CODE:  black_q = pwdata[7:0];
					REG_WHITE_CODE:  white_q = pwdata[7:0];
					REG_INVERT_CODE: invert_q = pwdata[7:0];
					REG_SIDE_BYTES:  side_q = pwdata[4:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pack_char(pixel_char, final_char);
			if (out_valid && !out_stall) begin
				got = '{and_byte: and_byte, xor_byte: xor_byte, copies: copies,
					is_padding: is_padding, end_of_mask: end_of_mask,
					length_error: length_error};
				if (mask_words_due.size() == 0) begin
					report_mismatch($sformatf("word %0d arrived with none expected (%p)",
						word_count, got));
				end else begin
					want = mask_words_due.pop_front();
					check_field("and_byte", got.and_byte, want.and_byte);
					check_field("xor_byte", got.xor_byte, want.xor_byte);
					check_field("copies", got.copies, want.copies);
					check_field("is_padding", got.is_padding, want.is_padding);
					check_field("end_of_mask", got.end_of_mask, want.end_of_mask);
					check_field("length_error", got.length_error, want.length_error);
				end
				word_count++;
			end
		end
		words_pending = mask_words_due.size();
	end

endmodule

// ===== verif/cursor_mask_packer_top_test.sv =====
`timescale 1ns / 1ps
// Top of the cursor mask packer testbench: clock, reset, stimulus, back-pressure and verdict.
module cursor_mask_packer_top_test;
	import cmp_pkg::*;

	// A cycle with no word moving on either channel counts toward the watchdog.
	// The longest legal quiet stretch is a long stall or gap plus a register
	// write and the settle time, far below this limit.
	localparam int IDLE_LIMIT = 500;
	// Cycles allowed after the last expected word for a word that produces no
	// output to finish inside the block.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_CHARS = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  pixel_char = '0;
	logic        final_char = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  and_byte;
	logic [7:0]  xor_byte;
	logic [7:0]  copies;
	logic        is_padding;
	logic        end_of_mask;
	logic        length_error;
	int          mismatches;
	int          words_pending;

	// Percent chance of a gap before each input word and of a stall burst on
	// each output cycle. Both change from picture to picture.
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	// Shadow of the register values, used only to pick characters and lengths.
	logic [7:0] black_now = BLACK_RESET;
	logic [7:0] white_now = WHITE_RESET;
	logic [7:0] invert_now = INVERT_RESET;
	logic [4:0] side_now = SIDE_RESET;

	cursor_mask_packer_top u_dut (.*);

	cursor_mask_packer_checker u_checker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Most idle stretches are short; about one in five is long.
	function automatic int idle_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Characters are mostly one of the three configured codes, so that all
	// pixel kinds show up, with some arbitrary bytes that read as transparent.
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 7))
			0, 1: return black_now;
			2, 3: return white_now;
			4: return invert_now;
			default: return 8'($urandom);
		endcase
	endfunction

	// Output back-pressure: a stall burst starts with chance stall_pct and
	// then holds for its whole length.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left <= idle_len() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: ends the run if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Offers one character and returns at the clock edge that takes it. The
	// handshake is sampled at the falling edge, where inputs and outputs are
	// both settled, so the decision does not depend on event order at the
	// rising edge. Valid stays high on return; callers that do not send again
	// at once lower it.
	task automatic send_char(input logic [7:0] ch, input logic last);
		int   gap;
		logic taken;
		if ($urandom_range(0, 99) < gap_pct) begin
			gap = idle_len();
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_char <= ch;
		final_char <= last;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Sends count random characters, the last one marked final when close is set.
	task automatic send_run(input int count, input logic close);
		for (int i = 0; i < count; i++)
			send_char(pick_char(), close && (i == count - 1));
	endtask

	// Holds the input back until every predicted word has come out, then lets
	// the block settle. Register writes only happen after this.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (words_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write: setup, then access until pready. The upper data bits are
	// random, since only the low bits of each register count.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		logic rdy;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_BLACK_CODE:  black_now = val;
			REG_WHITE_CODE:  white_now = val;
			REG_INVERT_CODE: invert_now = val;
			REG_SIDE_BYTES:  side_now = val[4:0];
			default: ;
		endcase
	endtask

	// Side 1 most often; the rest covers other odd and even sides, the largest
	// ones, zero and values above range.
	function automatic logic [4:0] pick_side();
		case ($urandom_range(0, 11))
			0, 1, 2, 3: return 5'd1;
			4: return 5'd3;
			5: return 5'd5;
			6: return 5'd2;
			7: return 5'd15;
			8: return 5'd16;
			9: return 5'd0;
			10: return 5'($urandom_range(17, 31));
			default: return 5'($urandom_range(1, 16));
		endcase
	endfunction

	initial begin
		logic [7:0] row8 [8];
		logic [4:0] side_eff;
		int         sent;
		int         count;
		logic       close;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset codes and side 4: one full byte of black, white, invert and a
		// transparent blank, left open so the next picture continues it.
		row8 = '{"X", ".", "o", " ", "X", "X", ".", "o"};
		foreach (row8[i]) send_char(row8[i], 1'b0);
		wait_idle();

		// Extreme codes and side 1, changed in the middle of that picture. The
		// byte ends a row, so a row pad follows it; the single trailing final
		// character leaves a partial byte that is dropped and flagged.
		write_reg(REG_BLACK_CODE, 8'h00);
		write_reg(REG_WHITE_CODE, 8'hff);
		write_reg(REG_INVERT_CODE, 8'h5a);
		write_reg(REG_SIDE_BYTES, 8'd1);
		row8 = '{8'h00, 8'hff, 8'h5a, 8'ha5, 8'hff, 8'h00, 8'h5a, 8'hc3};
		foreach (row8[i]) send_char(row8[i], 1'b0);
		send_char(8'h5a, 1'b1);
		wait_idle();

		// Side zero: a final character with no complete byte yields the lone
		// marker word, always with a length error.
		write_reg(REG_SIDE_BYTES, 8'd0);
		send_char(8'h81, 1'b1);
		wait_idle();

		// Side above the maximum acts as the maximum (even): a final character
		// that completes a byte marks that data word as the end.
		write_reg(REG_SIDE_BYTES, 8'd31);
		foreach (row8[i]) send_char(~row8[i], i == 7);
		wait_idle();

		// A full side-1 picture of the correct length with no idling at all,
		// then another under heavy back-pressure so that the sender must wait
		// on the output queue.
		write_reg(REG_BLACK_CODE, 8'h23);
		write_reg(REG_WHITE_CODE, 8'h2e);
		write_reg(REG_INVERT_CODE, 8'h40);
		write_reg(REG_SIDE_BYTES, 8'd1);
		send_run(64, 1'b1);
		wait_idle();
		stall_pct = 60;
		send_run(64, 1'b1);
		wait_idle();

		// Random pictures. Now and then the sender waits for the block to go
		// idle and the registers change; a picture left without its final
		// character then carries on under the new side.
		sent = 0;
		while (sent < RANDOM_CHARS) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_idle();
				if ($urandom_range(0, 2) == 0) begin
					write_reg(REG_BLACK_CODE, 8'($urandom));
					write_reg(REG_WHITE_CODE, 8'($urandom));
					write_reg(REG_INVERT_CODE,
						($urandom_range(0, 3) == 0) ? white_now : 8'($urandom));
				end
				write_reg(REG_SIDE_BYTES, 8'(pick_side()));
			end
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 10;
				default: gap_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 10;
				default: stall_pct = 40;
			endcase
			side_eff = (side_now > 5'd16) ? 5'd16 : side_now;
			if (side_eff == 5'd1 && $urandom_range(0, 1) == 1)
				count = 64;
			else if ($urandom_range(0, 5) == 0)
				count = 8 * side_eff + $urandom_range(1, 16);
			else
				count = $urandom_range(1, 40);
			// The last run is cut short so the total stays on budget.
			if (count > RANDOM_CHARS - sent)
				count = RANDOM_CHARS - sent;
			close = ($urandom_range(0, 6) != 0);
			send_run(count, close);
			sent += count;
		end

		stall_pct = 0;
		wait_idle();
		if (mismatches == 0 && words_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/cmp_pkg.sv
src/cursor_mask_packer_top.sv
src/cmp_checker.sv
verif/cursor_mask_packer_checker.sv
verif/cursor_mask_packer_top_test.sv
